FILE: design/etrd_pkg.sv
package etrd_pkg;

    typedef enum logic [2:0] {
        CFG_NM_PER_COUNT    = 3'd0,
        CFG_REVERSE_GAP_US  = 3'd1,
        CFG_REVERSE_CONFIRM = 3'd2,
        CFG_MAX_METERS      = 3'd3,
        CFG_INVERT          = 3'd4
    } t_cfg_idx;

    localparam logic [23:0] RST_NM_PER_COUNT    = 24'd10000;
    localparam logic [31:0] RST_REVERSE_GAP_US  = 32'd50000;
    localparam logic [7:0]  RST_REVERSE_CONFIRM = 8'd4;
    localparam logic [23:0] RST_CAP_CM          = 24'd1000000;

    localparam logic [6:0]  CM_PER_M   = 7'd100;
    localparam logic [7:0]  STREAK_MAX = 8'hFF;

    // nm / 10^7 = (nm >> 7) / 78125; reciprocal is floor(2^40 / 78125)
    localparam logic [23:0] DIV_RECIP = 24'd14073748;
    localparam logic [16:0] DIV_ODD   = 17'd78125;
    localparam logic [18:0] DIV_ODD_1 = 19'd78125;
    localparam logic [18:0] DIV_ODD_2 = 19'd156250;
    localparam logic [18:0] DIV_ODD_3 = 19'd234375;

    typedef struct packed {
        logic [23:0] scale_nm;
        logic [31:0] reverse_gap_us;
        logic [7:0]  reverse_confirm;
        logic [23:0] cap_cm;
        logic        invert;
    } t_cfg;

    typedef struct packed {
        logic [15:0] fwd;
        logic [15:0] rev;
        logic        ovf;
        logic [31:0] now_ms;
        logic [31:0] now_us;
        logic        take_win;
        logic        take_rev;
        logic        clr;
    } t_poll;

    typedef struct packed {
        t_poll       poll;
        logic [39:0] travel_add;
    } t_item;

    typedef struct packed {
        logic [47:0] distance_nm;
        logic [31:0] window;
        logic        hit;
        logic        active;
        logic [31:0] pulse_ms;
    } t_report;

    typedef struct packed {
        logic ld_mul;
        logic ld_fix;
    } t_div_ctl;

endpackage

FILE: design/etrd_tracker.sv
module etrd_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_upd,
    input  etrd_pkg::t_item  i_item,
    input  logic [31:0]      i_gap_us,
    input  logic [7:0]       i_confirm,
    output etrd_pkg::t_report o_report
);
    import etrd_pkg::*;

    logic [47:0] r_dist, n_dist;
    logic [31:0] r_win,  n_win;
    logic        r_hit,  n_hit;
    logic [7:0]  r_streak, n_streak;
    logic [31:0] r_lrt,  n_lrt;
    logic [31:0] r_pt,   n_pt;

    logic [47:0] acc_nm;
    logic [31:0] win;
    logic        hit;
    logic [7:0]  streak;
    logic [31:0] lrt;
    logic        active;
    logic [48:0] dist_sum;
    logic [32:0] win_sum_f;
    logic [32:0] win_sum_r;
    logic [31:0] gap_seen;
    logic [7:0]  rev_add;
    logic [8:0]  streak_sum;

    always_comb begin
        acc_nm = r_dist;
        win    = r_win;
        hit    = r_hit;
        streak = r_streak;
        lrt    = r_lrt;
        n_pt   = r_pt;

        if (i_item.poll.clr) begin
            acc_nm = '0;
            win    = '0;
            hit    = 1'b0;
            streak = '0;
            lrt    = '0;
        end

        active = (i_item.poll.fwd != 16'd0) || (i_item.poll.rev != 16'd0) || i_item.poll.ovf;
        if (active) begin
            n_pt = i_item.poll.now_ms;
        end

        dist_sum  = {1'b0, acc_nm} + {9'd0, i_item.travel_add};
        win_sum_f = {1'b0, win} + {17'd0, i_item.poll.fwd};
        if (i_item.poll.fwd != 16'd0) begin
            streak = '0;
            win    = win_sum_f[32] ? 32'hFFFF_FFFF : win_sum_f[31:0];
            acc_nm = dist_sum[48] ? 48'hFFFF_FFFF_FFFF : dist_sum[47:0];
        end

        win_sum_r  = {1'b0, win} + {17'd0, i_item.poll.rev};
        gap_seen   = i_item.poll.now_us - lrt;
        rev_add    = (i_item.poll.rev[15:8] != 8'd0) ? STREAK_MAX : i_item.poll.rev[7:0];
        streak_sum = 9'd0;
        if (i_item.poll.rev != 16'd0) begin
            win = win_sum_r[32] ? 32'hFFFF_FFFF : win_sum_r[31:0];
            if ((streak != 8'd0) && (gap_seen > i_gap_us)) begin
                streak = '0;
            end
            lrt        = i_item.poll.now_us;
            streak_sum = {1'b0, streak} + {1'b0, rev_add};
            streak     = streak_sum[8] ? STREAK_MAX : streak_sum[7:0];
            if (streak >= i_confirm) begin
                hit    = 1'b1;
                streak = '0;
            end
        end

        o_report.distance_nm = acc_nm;
        o_report.window      = win;
        o_report.hit         = hit;
        o_report.active      = active;
        o_report.pulse_ms    = n_pt;

        n_dist   = acc_nm;
        n_win    = i_item.poll.take_win ? 32'd0 : win;
        n_hit    = i_item.poll.take_rev ? 1'b0 : hit;
        n_streak = streak;
        n_lrt    = lrt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist   <= '0;
            r_win    <= '0;
            r_hit    <= 1'b0;
            r_streak <= '0;
            r_lrt    <= '0;
            r_pt     <= '0;
        end else if (i_upd) begin
            r_dist   <= n_dist;
            r_win    <= n_win;
            r_hit    <= n_hit;
            r_streak <= n_streak;
            r_lrt    <= n_lrt;
            r_pt     <= n_pt;
        end
    end

endmodule

FILE: design/etrd_cm_div.sv
module etrd_cm_div (
    input  logic               i_clk,
    input  etrd_pkg::t_div_ctl i_ctl,
    input  logic [47:0]        i_distance_nm,
    input  logic [23:0]        i_cap_cm,
    output logic [23:0]        o_travel_cm
);
    import etrd_pkg::*;

    logic [48:0] r_prod_a;
    logic [18:0] r_xlo_a;
    logic [24:0] r_q_b;
    logic [18:0] r_mlo_b;
    logic [18:0] r_xlo_b;

    logic [48:0] n_prod_a;
    logic [24:0] q_est;
    logic [41:0] n_mul_b;
    logic [18:0] rem;
    logic [1:0]  corr;
    logic [24:0] cm;

    assign n_prod_a = {24'd0, i_distance_nm[47:23]} * {25'd0, DIV_RECIP};
    assign q_est    = r_prod_a[48:24];
    assign n_mul_b  = {17'd0, q_est} * {25'd0, DIV_ODD};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_prod_a <= n_prod_a;
            r_xlo_a  <= i_distance_nm[25:7];
        end
        if (i_ctl.ld_fix) begin
            r_q_b   <= q_est;
            r_mlo_b <= n_mul_b[18:0];
            r_xlo_b <= r_xlo_a;
        end
    end

    // estimate falls short by at most three; fix up from the remainder
    always_comb begin
        rem  = r_xlo_b - r_mlo_b;
        corr = 2'd0;
        if (rem >= DIV_ODD_3) begin
            corr = 2'd3;
        end else if (rem >= DIV_ODD_2) begin
            corr = 2'd2;
        end else if (rem >= DIV_ODD_1) begin
            corr = 2'd1;
        end
        cm          = r_q_b + {23'd0, corr};
        o_travel_cm = (cm > {1'b0, i_cap_cm}) ? i_cap_cm : cm[23:0];
    end

endmodule

FILE: design/encoder_travel_reverse_detector_core.sv
// Encoder travel and reverse detector. Each poll item carries forward and reverse
// count deltas, an overflow flag and the ms/us times, and gives exactly one result
// item: forward travel in cm (capped at max metres times 100), the saturating pulse
// window, the latched reverse-hit flag, activity and the time of the last active
// poll. One item is taken every cycle while the output is not stalled; each result
// passes through the input register, count scaling multiply, state update, two
// multiply stages of the nm-to-cm division and result register. Travel, window and
// streak state is updated once per item. Configuration registers must be written
// through the write port while no item is in flight; the block does not enforce
// this. Stall on the output backs up through the stages only once all are full.
module encoder_travel_reverse_detector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_forward_count,
    input  logic [15:0] i_reverse_count,
    input  logic        i_overflow,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_now_us,
    input  logic        i_take_window,
    input  logic        i_take_reverse,
    input  logic        i_clear_all,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_travel_cm,
    output logic [31:0] o_pulse_window,
    output logic        o_reverse_hit,
    output logic        o_activity,
    output logic [31:0] o_last_pulse_ms
);
    import etrd_pkg::*;

    t_cfg    r_cfg;
    logic    r_v0, r_v1, r_v2, r_v3, r_v4, r_vo;
    t_poll   r_s0;
    t_item   r_s1, n_s1;
    t_report r_s2, r_s3, r_s4, n_s2;
    logic [23:0] r_o_travel_cm;
    t_report     r_o_rpt;

    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic upd;
    logic [23:0] n_cap_cm;
    logic [23:0] div_cm;
    t_div_ctl    div_ctl;

    assign rdy_o = !r_vo || !i_stall;
    assign rdy4  = !r_v4 || rdy_o;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign rdy0  = !r_v0 || rdy1;
    assign o_stall = !rdy0;
    assign upd     = r_v1 && rdy2;

    assign n_cap_cm = {7'd0, i_cfg_data[16:0]} * {17'd0, CM_PER_M};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_nm        <= RST_NM_PER_COUNT;
            r_cfg.reverse_gap_us  <= RST_REVERSE_GAP_US;
            r_cfg.reverse_confirm <= RST_REVERSE_CONFIRM;
            r_cfg.cap_cm          <= RST_CAP_CM;
            r_cfg.invert          <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NM_PER_COUNT:    r_cfg.scale_nm        <= i_cfg_data[23:0];
                CFG_REVERSE_GAP_US:  r_cfg.reverse_gap_us  <= i_cfg_data;
                CFG_REVERSE_CONFIRM: r_cfg.reverse_confirm <= i_cfg_data[7:0];
                CFG_MAX_METERS:      r_cfg.cap_cm          <= n_cap_cm;
                CFG_INVERT:          r_cfg.invert          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_s1.poll = r_s0;
        if (r_cfg.invert) begin
            n_s1.poll.fwd = r_s0.rev;
            n_s1.poll.rev = r_s0.fwd;
        end
        n_s1.travel_add = {24'd0, n_s1.poll.fwd} * {16'd0, r_cfg.scale_nm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy0)  r_v0 <= i_valid;
            if (rdy1)  r_v1 <= r_v0;
            if (rdy2)  r_v2 <= r_v1;
            if (rdy3)  r_v3 <= r_v2;
            if (rdy4)  r_v4 <= r_v3;
            if (rdy_o) r_vo <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_s0.fwd      <= i_forward_count;
            r_s0.rev      <= i_reverse_count;
            r_s0.ovf      <= i_overflow;
            r_s0.now_ms   <= i_now_ms;
            r_s0.now_us   <= i_now_us;
            r_s0.take_win <= i_take_window;
            r_s0.take_rev <= i_take_reverse;
            r_s0.clr      <= i_clear_all;
        end
        if (rdy1) r_s1 <= n_s1;
        if (rdy2) r_s2 <= n_s2;
        if (rdy3) r_s3 <= r_s2;
        if (rdy4) r_s4 <= r_s3;
        if (rdy_o) begin
            r_o_rpt       <= r_s4;
            r_o_travel_cm <= div_cm;
        end
    end

    etrd_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_item    (r_s1),
        .i_gap_us  (r_cfg.reverse_gap_us),
        .i_confirm (r_cfg.reverse_confirm),
        .o_report  (n_s2)
    );

    assign div_ctl.ld_mul = rdy3;
    assign div_ctl.ld_fix = rdy4;

    etrd_cm_div u_cm_div (
        .i_clk         (i_clk),
        .i_ctl         (div_ctl),
        .i_distance_nm (r_s2.distance_nm),
        .i_cap_cm      (r_cfg.cap_cm),
        .o_travel_cm   (div_cm)
    );

    assign o_valid         = r_vo;
    assign o_travel_cm     = r_o_travel_cm;
    assign o_pulse_window  = r_o_rpt.window;
    assign o_reverse_hit   = r_o_rpt.hit;
    assign o_activity      = r_o_rpt.active;
    assign o_last_pulse_ms = r_o_rpt.pulse_ms;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_o_travel_cm <= r_cfg.cap_cm))
        else $error("travel above cap");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v0 && r_v1 && r_v2 && r_v3 && r_v4 && r_vo))
        else $error("input stalled with a free stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_v4))
        else $error("result without an item in the last stage");

endmodule
